[hdl/pfa_pkg.sv]
// Package for the page frame allocator: field widths, codes and the result record.
// Used by the allocator top and its output register; depends on nothing.
package pfa_pkg;

  // Default sizes of the frame table and of the free batch buffer.
  localparam int unsigned DEF_NUM_FRAMES = 4096;
  localparam int unsigned DEF_MAX_BATCH  = 16;

  // Fixed widths of the request and result fields.
  localparam int FRAME_W = 12;
  localparam int CNT_W   = 13;
  localparam int CFG_W   = 13;
  localparam int PCNT_W  = 5;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_INIT         = 2'd0,
    MODE_ALLOC_ANY    = 2'd1,
    MODE_ALLOC_ZEROED = 2'd2,
    MODE_FREE         = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_SHORTFALL     = 2'd1,
    STATUS_NOT_ALLOCATED = 2'd2,
    STATUS_TOO_LONG      = 2'd3
  } status_e;

  // Per-frame state codes held in the state memory.
  localparam logic [1:0] FS_BUSY = 2'd0;
  localparam logic [1:0] FS_FREE = 2'd1;

  // Configuration register indexes.
  localparam logic CFG_TOTAL_FRAMES = 1'b0;
  localparam logic CFG_FIRST_FREE   = 1'b1;

  // One result item.
  typedef struct packed {
    status_e              status;
    logic                 has_frame;
    logic [FRAME_W-1:0]   frame;
    logic                 needs_zeroing;
    logic                 last;
    logic [CNT_W-1:0]     available;
  } result_t;

endpackage

[hdl/pfa_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; used for the frame state, next link and batch memories.
module pfa_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pfa_out_reg.sv]
// Output holding register for result items, parting the allocator from the sink.
// Depends on pfa_pkg for the result record.
module pfa_out_reg
  import pfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  result_t            res_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               has_frame_o,
  output logic [FRAME_W-1:0] out_frame_o,
  output logic               needs_zeroing_o,
  output logic               last_o,
  output logic [CNT_W-1:0]   available_o
);

  logic    valid_q;
  result_t res_q;

  // A new result may be loaded when the register is empty or being drained.
  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      res_q   <= '0;
    end else if (load_i && ready_o) begin
      valid_q <= 1'b1;
      res_q   <= res_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = valid_q;
  assign status_o        = res_q.status;
  assign has_frame_o     = res_q.has_frame;
  assign out_frame_o     = res_q.frame;
  assign needs_zeroing_o = res_q.needs_zeroing;
  assign last_o          = res_q.last;
  assign available_o     = res_q.available;

endmodule

[hdl/page_frame_free_list_allocator.sv]
// Page frame allocator: free and zeroed lists threaded through a next link memory.
// Initialize writes the state and link of every frame in the table; an allocate pops one page
// at a time, reading the next link memory; each freed frame is checked against earlier ones.
// One request is worked on at a time; results leave through a one-entry output register.
// Reset clears heads, counts, batch length and control; the memories are not cleared, and the
// state and link memories are written by initialize.
module page_frame_free_list_allocator
  import pfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = DEF_NUM_FRAMES,
  parameter int unsigned MAX_BATCH  = DEF_MAX_BATCH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [PCNT_W-1:0]  page_count_i,
  input  logic [FRAME_W-1:0] frame_i,
  input  logic               last_entry_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               has_frame_o,
  output logic [FRAME_W-1:0] out_frame_o,
  output logic               needs_zeroing_o,
  output logic               last_o,
  output logic [CNT_W-1:0]   available_o
);

  localparam int FW  = $clog2(NUM_FRAMES);
  localparam int LKW = FW + 1;
  localparam int CW  = $clog2(NUM_FRAMES + 1);
  localparam int LW  = $clog2(MAX_BATCH + 1);
  localparam int BW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam logic [LKW-1:0] NULL_LINK = {LKW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_POP, S_POP_WAIT, S_VAL_RD, S_VAL_GOT, S_VAL_ST,
    S_DUP_RD, S_DUP_CMP, S_COM_RD, S_COM_WR, S_RESP
  } state_e;

  state_e         state_q;
  logic [CFG_W-1:0] total_q, first_free_q;
  logic [LKW-1:0] free_head_q, zero_head_q;
  logic [CW-1:0]  free_cnt_q, zero_cnt_q, avail_q, idx_q;
  logic [LW-1:0]  blen_q, bi_q, bj_q;
  logic           bfault_q, zeroed_req_q, pop_free_q;
  logic [PCNT_W-1:0] cnt_q, k_q;
  logic [FRAME_W-1:0] fi_q;
  status_e        status_q;

  logic           in_fire, res_valid, res_ready, pop_free, pop_last;
  result_t        res;
  logic [CW-1:0]  eff_tot, idx_nxt;
  logic [CW:0]    avail_now;
  logic [LKW-1:0] pop_head, popped;
  mode_e          mode;

  logic           st_we, st_re, lk_we, lk_re, bf_we, bf_re;
  logic [FW-1:0]  st_waddr, st_raddr, lk_waddr, lk_raddr;
  logic [1:0]     st_wdata, st_rdata;
  logic [LKW-1:0] lk_wdata, lk_rdata;
  logic [BW-1:0]  bf_waddr, bf_raddr;
  logic [FRAME_W-1:0] bf_wdata, buf_rdata;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign eff_tot    = (32'(total_q) < 32'(NUM_FRAMES)) ? CW'(total_q) : CW'(NUM_FRAMES);
  assign idx_nxt    = CW'(idx_q + 1'b1);
  assign avail_now  = {1'b0, free_cnt_q} + {1'b0, zero_cnt_q};
  assign pop_free   = zeroed_req_q ? (zero_cnt_q == '0) : (free_cnt_q != '0);
  assign pop_head   = pop_free ? free_head_q : zero_head_q;
  assign popped     = pop_free_q ? free_head_q : zero_head_q;
  assign pop_last   = (PCNT_W'(k_q + 1'b1) == cnt_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= CFG_W'(4096);
      first_free_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TOTAL_FRAMES: total_q      <= cfg_wdata_i;
        CFG_FIRST_FREE:   first_free_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Memory port selection and the result presented to the output register.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx_q[FW-1:0];
    st_wdata = FS_BUSY;
    st_re    = 1'b0;
    st_raddr = FW'(buf_rdata);
    lk_we    = 1'b0;
    lk_waddr = idx_q[FW-1:0];
    lk_wdata = NULL_LINK;
    lk_re    = 1'b0;
    lk_raddr = pop_head[FW-1:0];
    bf_we    = 1'b0;
    bf_waddr = blen_q[BW-1:0];
    bf_wdata = frame_i;
    bf_re    = 1'b0;
    bf_raddr = bi_q[BW-1:0];
    res_valid         = 1'b0;
    res.status        = status_q;
    res.has_frame     = 1'b0;
    res.frame         = '0;
    res.needs_zeroing = 1'b0;
    res.last          = 1'b1;
    res.available     = CNT_W'(avail_now);
    unique case (state_q)
      S_IDLE: begin
        bf_we = in_fire && (mode == MODE_FREE) && (32'(blen_q) < 32'(MAX_BATCH));
      end
      S_INIT: begin
        if (idx_q < eff_tot) begin
          st_we    = 1'b1;
          lk_we    = 1'b1;
          st_wdata = (32'(idx_q) < 32'(first_free_q)) ? FS_BUSY : FS_FREE;
          lk_wdata = (idx_nxt < eff_tot) ? LKW'(idx_nxt) : NULL_LINK;
        end
      end
      S_POP: begin
        st_we    = 1'b1;
        st_waddr = pop_head[FW-1:0];
        lk_re    = 1'b1;
      end
      S_POP_WAIT: begin
        res_valid         = 1'b1;
        res.status        = STATUS_OK;
        res.has_frame     = 1'b1;
        res.frame         = FRAME_W'(popped);
        res.needs_zeroing = zeroed_req_q && pop_free_q;
        res.last          = pop_last;
        res.available     = CNT_W'(avail_q);
      end
      S_VAL_RD, S_COM_RD: bf_re = 1'b1;
      S_VAL_GOT: st_re = 1'b1;
      S_DUP_RD: begin
        bf_re    = 1'b1;
        bf_raddr = bj_q[BW-1:0];
      end
      S_COM_WR: begin
        st_we    = 1'b1;
        st_waddr = FW'(buf_rdata);
        st_wdata = FS_FREE;
        lk_we    = 1'b1;
        lk_waddr = FW'(buf_rdata);
        lk_wdata = free_head_q;
      end
      S_RESP: res_valid = 1'b1;
      default: ;
    endcase
  end

  // Sequencer: initialize sweep, pops, batch validation and commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_head_q  <= NULL_LINK;
      zero_head_q  <= NULL_LINK;
      free_cnt_q   <= '0;
      zero_cnt_q   <= '0;
      avail_q      <= '0;
      idx_q        <= '0;
      blen_q       <= '0;
      bi_q         <= '0;
      bj_q         <= '0;
      bfault_q     <= 1'b0;
      zeroed_req_q <= 1'b0;
      pop_free_q   <= 1'b0;
      cnt_q        <= '0;
      k_q          <= '0;
      fi_q         <= '0;
      status_q     <= STATUS_OK;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (mode)
              MODE_INIT: begin
                idx_q    <= '0;
                blen_q   <= '0;
                bfault_q <= 1'b0;
                state_q  <= S_INIT;
              end
              MODE_ALLOC_ANY, MODE_ALLOC_ZEROED: begin
                cnt_q        <= page_count_i;
                k_q          <= '0;
                zeroed_req_q <= (mode == MODE_ALLOC_ZEROED);
                avail_q      <= CW'(avail_now - (CW+1)'(page_count_i));
                if (32'(page_count_i) > 32'(MAX_BATCH)) begin
                  status_q <= STATUS_TOO_LONG;
                  state_q  <= S_RESP;
                end else if (page_count_i == '0) begin
                  status_q <= STATUS_OK;
                  state_q  <= S_RESP;
                end else if (32'(page_count_i) > 32'(avail_now)) begin
                  status_q <= STATUS_SHORTFALL;
                  state_q  <= S_RESP;
                end else begin
                  state_q <= S_POP;
                end
              end
              default: begin
                // Free entry: buffer it, or mark the batch too long; the last entry
                // either reports a fault or starts the validation of the batch.
                if (last_entry_i) begin
                  if (bfault_q || (32'(blen_q) >= 32'(MAX_BATCH))) begin
                    status_q <= STATUS_TOO_LONG;
                    blen_q   <= '0;
                    bfault_q <= 1'b0;
                    state_q  <= S_RESP;
                  end else begin
                    blen_q  <= LW'(blen_q + 1'b1);
                    bi_q    <= '0;
                    state_q <= S_VAL_RD;
                  end
                end else if (32'(blen_q) < 32'(MAX_BATCH)) begin
                  blen_q <= LW'(blen_q + 1'b1);
                end else begin
                  bfault_q <= 1'b1;
                end
              end
            endcase
          end
        end
        S_INIT: begin
          if (idx_q < eff_tot) begin
            idx_q <= idx_nxt;
          end else begin
            if (32'(first_free_q) < 32'(eff_tot)) begin
              free_head_q <= LKW'(first_free_q);
              free_cnt_q  <= CW'(eff_tot - CW'(first_free_q));
            end else begin
              free_head_q <= NULL_LINK;
              free_cnt_q  <= '0;
            end
            zero_head_q <= NULL_LINK;
            zero_cnt_q  <= '0;
            status_q    <= STATUS_OK;
            state_q     <= S_RESP;
          end
        end
        S_POP: begin
          pop_free_q <= pop_free;
          state_q    <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          if (res_ready) begin
            if (pop_free_q) begin
              free_head_q <= lk_rdata;
              free_cnt_q  <= CW'(free_cnt_q - 1'b1);
            end else begin
              zero_head_q <= lk_rdata;
              zero_cnt_q  <= CW'(zero_cnt_q - 1'b1);
            end
            if (pop_last) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= PCNT_W'(k_q + 1'b1);
              state_q <= S_POP;
            end
          end
        end
        S_VAL_RD: state_q <= S_VAL_GOT;
        S_VAL_GOT: begin
          fi_q <= buf_rdata;
          bj_q <= '0;
          if (32'(buf_rdata) >= 32'(eff_tot)) begin
            status_q <= STATUS_NOT_ALLOCATED;
            blen_q   <= '0;
            state_q  <= S_RESP;
          end else begin
            state_q <= S_VAL_ST;
          end
        end
        S_VAL_ST: begin
          if (st_rdata != FS_BUSY) begin
            status_q <= STATUS_NOT_ALLOCATED;
            blen_q   <= '0;
            state_q  <= S_RESP;
          end else if (bj_q == bi_q) begin
            if (LW'(bi_q + 1'b1) == blen_q) begin
              bi_q    <= '0;
              state_q <= S_COM_RD;
            end else begin
              bi_q    <= LW'(bi_q + 1'b1);
              state_q <= S_VAL_RD;
            end
          end else begin
            state_q <= S_DUP_RD;
          end
        end
        S_DUP_RD: state_q <= S_DUP_CMP;
        S_DUP_CMP: begin
          // Compare an earlier entry of the batch with the one under check.
          if (buf_rdata == fi_q) begin
            status_q <= STATUS_NOT_ALLOCATED;
            blen_q   <= '0;
            state_q  <= S_RESP;
          end else if (LW'(bj_q + 1'b1) == bi_q) begin
            if (LW'(bi_q + 1'b1) == blen_q) begin
              bi_q    <= '0;
              state_q <= S_COM_RD;
            end else begin
              bi_q    <= LW'(bi_q + 1'b1);
              state_q <= S_VAL_RD;
            end
          end else begin
            bj_q    <= LW'(bj_q + 1'b1);
            state_q <= S_DUP_RD;
          end
        end
        S_COM_RD: state_q <= S_COM_WR;
        S_COM_WR: begin
          free_head_q <= LKW'(buf_rdata);
          free_cnt_q  <= CW'(free_cnt_q + 1'b1);
          if (LW'(bi_q + 1'b1) == blen_q) begin
            status_q <= STATUS_OK;
            blen_q   <= '0;
            state_q  <= S_RESP;
          end else begin
            bi_q    <= LW'(bi_q + 1'b1);
            state_q <= S_COM_RD;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Frame state memory.
  pfa_ram #(.W(2), .D(NUM_FRAMES)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Next link memory threading both lists.
  pfa_ram #(.W(LKW), .D(NUM_FRAMES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  // Free batch buffer.
  pfa_ram #(.W(FRAME_W), .D(MAX_BATCH)) u_batch_ram (
    .clk_i   (clk_i),
    .we_i    (bf_we),
    .waddr_i (bf_waddr),
    .wdata_i (bf_wdata),
    .re_i    (bf_re),
    .raddr_i (bf_raddr),
    .rdata_o (buf_rdata)
  );

  // Result register towards the sink.
  pfa_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (res_valid),
    .res_i           (res),
    .ready_o         (res_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .has_frame_o     (has_frame_o),
    .out_frame_o     (out_frame_o),
    .needs_zeroing_o (needs_zeroing_o),
    .last_o          (last_o),
    .available_o     (available_o)
  );

  // An empty list always has a null head.
  a_free_empty_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q == '0 |-> free_head_q == NULL_LINK) else $error("free list head not null");

  a_zero_empty_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_cnt_q == '0 |-> zero_head_q == NULL_LINK) else $error("zeroed list head not null");

  // A pop is only started when some list holds a frame.
  a_pop_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> (free_cnt_q != '0 || zero_cnt_q != '0))
    else $error("pop from empty lists");

  // The batch buffer never overfills.
  a_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(blen_q) <= 32'(MAX_BATCH)) else $error("batch length overflow");

endmodule

[test/page_frame_free_list_allocator_tb.sv]
// Testbench for the page frame allocator. It drives requests over valid/ready and keeps its own
// copy of the free and zeroed lists to predict every result. Depends on pfa_pkg and the top module.
module page_frame_free_list_allocator_tb;
  import pfa_pkg::*;

  localparam int NF = DEF_NUM_FRAMES;
  localparam int MB = DEF_MAX_BATCH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [12:0] NULL_LINK = '1;

  // Scoreboard: list state of the allocator and the queue of results still owed.
  class alloc_scoreboard;
    logic [1:0]  fstate[NF];
    logic [12:0] nlink[NF];
    logic [12:0] free_head, zero_head;
    int free_cnt, zero_cnt;
    logic [11:0] batch[MB];
    int blen;
    bit bfault;
    int total_reg, first_reg;
    result_t owed[$];
    int errors;

    function new();
      foreach (fstate[i]) begin
        fstate[i] = FS_BUSY;
        nlink[i] = '0;
      end
      free_head = NULL_LINK;
      zero_head = NULL_LINK;
      free_cnt = 0;
      zero_cnt = 0;
      blen = 0;
      bfault = 0;
      total_reg = 4096;
      first_reg = 0;
      errors = 0;
    endfunction

    function int eff_total();
      return (total_reg < NF) ? total_reg : NF;
    endfunction

    function void write_reg(logic idx, int val);
      if (idx == CFG_TOTAL_FRAMES) total_reg = val;
      else first_reg = val;
    endfunction

    function logic [12:0] take(inout logic [12:0] head, inout int cnt);
      logic [12:0] f;
      f = head;
      if (f < NF) begin
        head = nlink[f];
        fstate[f] = FS_BUSY;
      end else begin
        head = NULL_LINK;
      end
      if (cnt > 0) cnt--;
      return f;
    endfunction

    function void owe(status_e s, bit has, logic [11:0] fr, bit nz, bit lst);
      result_t r;
      r.status = s;
      r.has_frame = has;
      r.frame = fr;
      r.needs_zeroing = nz;
      r.last = lst;
      r.available = CNT_W'(free_cnt + zero_cnt);
      owed.push_back(r);
    endfunction

    // Applies one accepted request and queues the results it must cause.
    function void note_request(mode_e m, int cnt, int fr, bit le);
      logic [12:0] got[MB];
      bit nz[MB];
      int tot;
      status_e s;
      tot = eff_total();
      case (m)
        MODE_INIT: begin
          for (int i = 0; i < tot; i++) begin
            if (i < first_reg) begin
              fstate[i] = FS_BUSY;
            end else begin
              fstate[i] = FS_FREE;
              nlink[i] = (i + 1 < tot) ? 13'(i + 1) : NULL_LINK;
            end
          end
          if (first_reg < tot) begin
            free_head = 13'(first_reg);
            free_cnt = tot - first_reg;
          end else begin
            free_head = NULL_LINK;
            free_cnt = 0;
          end
          zero_head = NULL_LINK;
          zero_cnt = 0;
          blen = 0;
          bfault = 0;
          owe(STATUS_OK, 0, 0, 0, 1);
        end
        MODE_ALLOC_ANY, MODE_ALLOC_ZEROED: begin
          if (cnt > MB) owe(STATUS_TOO_LONG, 0, 0, 0, 1);
          else if (cnt == 0) owe(STATUS_OK, 0, 0, 0, 1);
          else if (cnt > free_cnt + zero_cnt) owe(STATUS_SHORTFALL, 0, 0, 0, 1);
          else begin
            for (int i = 0; i < cnt; i++) begin
              if (m == MODE_ALLOC_ANY) begin
                nz[i] = 0;
                if (free_cnt > 0) got[i] = take(free_head, free_cnt);
                else got[i] = take(zero_head, zero_cnt);
              end else if (zero_cnt > 0) begin
                nz[i] = 0;
                got[i] = take(zero_head, zero_cnt);
              end else begin
                nz[i] = 1;
                got[i] = take(free_head, free_cnt);
              end
            end
            for (int i = 0; i < cnt; i++)
              owe(STATUS_OK, 1, got[i][11:0], nz[i], i + 1 == cnt);
          end
        end
        default: begin
          // Free entry: buffered, and the whole batch is checked at its last entry.
          if (blen < MB) begin
            batch[blen] = 12'(fr);
            blen++;
          end else begin
            bfault = 1;
          end
          if (le) begin
            s = STATUS_OK;
            if (bfault) begin
              s = STATUS_TOO_LONG;
            end else begin
              for (int i = 0; i < blen && s == STATUS_OK; i++) begin
                if (batch[i] >= tot || fstate[batch[i]] != FS_BUSY) s = STATUS_NOT_ALLOCATED;
                for (int j = 0; j < i; j++)
                  if (batch[j] == batch[i]) s = STATUS_NOT_ALLOCATED;
              end
            end
            if (s == STATUS_OK) begin
              for (int i = 0; i < blen; i++) begin
                fstate[batch[i]] = FS_FREE;
                nlink[batch[i]] = free_head;
                free_head = 13'(batch[i]);
                free_cnt++;
              end
            end
            blen = 0;
            bfault = 0;
            owe(s, 0, 0, 0, 1);
          end
        end
      endcase
    endfunction

    // Compares one result from the block with the oldest one owed.
    function void check_result(result_t got);
      result_t e;
      if (owed.size() == 0) begin
        $error("result with nothing expected: status %0d frame %0d", got.status, got.frame);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.status != e.status) begin
        $error("status: expected %0d actual %0d", e.status, got.status);
        errors++;
      end
      if (got.has_frame != e.has_frame) begin
        $error("has_frame: expected %0d actual %0d", e.has_frame, got.has_frame);
        errors++;
      end
      if (got.frame != e.frame) begin
        $error("out_frame: expected %0d actual %0d", e.frame, got.frame);
        errors++;
      end
      if (got.needs_zeroing != e.needs_zeroing) begin
        $error("needs_zeroing: expected %0d actual %0d", e.needs_zeroing, got.needs_zeroing);
        errors++;
      end
      if (got.last != e.last) begin
        $error("last: expected %0d actual %0d", e.last, got.last);
        errors++;
      end
      if (got.available != e.available) begin
        $error("available: expected %0d actual %0d", e.available, got.available);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] mode = MODE_INIT;
  logic [PCNT_W-1:0] page_count = '0;
  logic [FRAME_W-1:0] frame = '0;
  logic last_entry = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic has_frame, needs_zeroing, last;
  logic [FRAME_W-1:0] out_frame;
  logic [CNT_W-1:0] available;

  alloc_scoreboard sb = new();
  result_t seen;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 0;
  bit hold_on = 0;
  int cycles = 0;

  page_frame_free_list_allocator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .page_count_i(page_count), .frame_i(frame), .last_entry_i(last_entry),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .has_frame_o(has_frame), .out_frame_o(out_frame),
    .needs_zeroing_o(needs_zeroing), .last_o(last), .available_o(available)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Long hold-off of the receiver once it is started, counted here in cycles.
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    hold_on = 1;
    repeat (400) @(negedge clk_i);
    hold_on = 0;
  end

  // Receiver: random stalls, held low during the long hold-off.
  always @(negedge clk_i) begin
    if (hold_on) begin
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      seen.status = status_e'(status);
      seen.has_frame = has_frame;
      seen.frame = out_frame;
      seen.needs_zeroing = needs_zeroing;
      seen.last = last;
      seen.available = available;
      sb.check_result(seen);
    end
  end

  // Offers one request and holds it until the block takes it.
  task automatic send(mode_e m, int pc, int fr, bit le);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid <= 1;
    mode <= m;
    page_count <= pc[PCNT_W-1:0];
    frame <= fr[FRAME_W-1:0];
    last_entry <= le;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(m, pc, fr, le);
  endtask

  // Waits for the block to go quiet, then writes both registers.
  task automatic configure(int tot, int first);
    @(negedge clk_i);
    in_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we <= 1;
    cfg_index <= CFG_TOTAL_FRAMES;
    cfg_wdata <= CFG_W'(tot);
    @(negedge clk_i);
    cfg_index <= CFG_FIRST_FREE;
    cfg_wdata <= CFG_W'(first);
    @(negedge clk_i);
    cfg_we <= 0;
    sb.write_reg(CFG_TOTAL_FRAMES, tot);
    sb.write_reg(CFG_FIRST_FREE, first);
  endtask

  // Sends a free batch of busy frames, optionally spoilt by a duplicate, an out of range
  // frame or a frame that is already free. Returns the number of requests sent.
  task automatic free_batch(int len, bit spoil, output int sent);
    int busy[$];
    int pick[$];
    int tot, idx;
    tot = sb.eff_total();
    for (int i = 0; i < tot; i++)
      if (sb.fstate[i] == FS_BUSY) busy.push_back(i);
    if (len > busy.size()) len = busy.size();
    repeat (len) begin
      idx = $urandom_range(0, busy.size() - 1);
      pick.push_back(busy[idx]);
      busy.delete(idx);
    end
    if (spoil || pick.size() == 0) begin
      case ($urandom_range(0, 2))
        0: if (pick.size() > 0) pick.push_back(pick[0]);
           else pick.push_back($urandom_range(0, 4095));
        1: if (tot < NF) pick.insert($urandom_range(0, pick.size()), $urandom_range(tot, 4095));
           else pick.push_back($urandom_range(0, 4095));
        default: if (sb.free_cnt > 0) pick.insert($urandom_range(0, pick.size()), sb.free_head);
                 else pick.push_back($urandom_range(0, 4095));
      endcase
    end
    sent = 0;
    foreach (pick[i]) begin
      // An allocate now and then in the middle of a batch.
      if ($urandom_range(99) < 5) begin
        send(MODE_ALLOC_ANY, $urandom_range(1, 3), $urandom, $urandom_range(1));
        sent++;
      end
      send(MODE_FREE, $urandom_range(0, 31), pick[i], i == pick.size() - 1);
      sent++;
    end
  endtask

  // One random request or sequence; returns the number of requests sent.
  task automatic random_step(output int sent);
    int r, lim, n;
    r = $urandom_range(99);
    sent = 1;
    if (r < 5) begin
      send(MODE_INIT, $urandom_range(0, 31), $urandom, $urandom_range(1));
    end else if (r < 45) begin
      lim = sb.free_cnt + sb.zero_cnt + 2;
      if (lim > MB) lim = MB;
      if ($urandom_range(99) < 80) n = $urandom_range(1, lim);
      else n = $urandom_range(0, 31);
      send($urandom_range(1) ? MODE_ALLOC_ANY : MODE_ALLOC_ZEROED, n, $urandom,
           $urandom_range(1));
    end else if (r < 88) begin
      n = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, MB);
      free_batch(n, $urandom_range(99) < 20, sent);
    end else if (r < 95) begin
      send(MODE_FREE, $urandom_range(0, 31), $urandom_range(0, 4095), $urandom_range(1));
    end else begin
      // Batch longer than the buffer.
      n = $urandom_range(MB + 1, MB + 3);
      for (int i = 0; i < n; i++)
        send(MODE_FREE, $urandom_range(0, 31), $urandom_range(0, 4095), i == n - 1);
      sent = n;
    end
  endtask

  // Main sequence.
  initial begin
    int ph_total[6] = '{37, 4096, 1, 64, 4096, 23};
    int ph_first[6] = '{5, 4000, 0, 64, 0, 11};
    int ph_idle[6]  = '{0, 74, 0, 14, 0, 74};
    int ph_stall[6] = '{0, 0, 74, 14, 74, 0};
    int done, n;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed part: eight free frames at the top of the largest table.
    configure(4096, 4088);
    send(MODE_INIT, 0, 0, 0);
    send(MODE_ALLOC_ANY, 0, 4095, 1);
    send(MODE_ALLOC_ANY, 17, 0, 0);
    send(MODE_ALLOC_ZEROED, 31, 0, 1);
    send(MODE_ALLOC_ANY, 5, 0, 0);
    send(MODE_ALLOC_ZEROED, 3, 0, 0);
    send(MODE_ALLOC_ANY, 1, 0, 0);
    send(MODE_FREE, 0, 4090, 0);
    send(MODE_FREE, 0, 4095, 1);
    send(MODE_FREE, 16, 0, 0);
    send(MODE_FREE, 16, 0, 1);
    send(MODE_FREE, 0, 4095, 1);
    send(MODE_ALLOC_ZEROED, 2, 0, 0);
    send(MODE_ALLOC_ANY, 16, 0, 0);

    // Directed part: one frame only, with an empty free range.
    configure(1, 4096);
    send(MODE_INIT, 0, 0, 0);
    send(MODE_ALLOC_ANY, 1, 0, 0);
    send(MODE_FREE, 0, 0, 1);
    send(MODE_ALLOC_ANY, 1, 0, 0);
    send(MODE_FREE, 0, 4095, 1);

    // Random phases with changing sizes and idling.
    for (int p = 0; p < 6; p++) begin
      configure(ph_total[p], ph_first[p]);
      idle_pct = ph_idle[p];
      stall_pct = ph_stall[p];
      send(MODE_INIT, 0, 0, 0);
      if (p == 0) hold_go = 1;
      done = 1;
      while (done < 55) begin
        random_step(n);
        done += n;
      end
    end

    @(negedge clk_i);
    in_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
